### sv/grtr_pkg.sv
`default_nettype none
package grtr_pkg;

  localparam int GLYPH_W = 8;
  localparam int GLYPH_H = 16;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 2'd1;

  localparam logic [12:0] CANVAS_WIDTH_RESET  = 13'd600;
  localparam logic [12:0] CANVAS_HEIGHT_RESET = 13'd800;

  // character codes used by the classifier and the pattern lookup
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TILDE   = 8'h7E;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_DELTA = 8'h20;

  localparam logic [6:0] CH_BANG    = 7'h21;
  localparam logic [6:0] CH_PERCENT = 7'h25;
  localparam logic [6:0] CH_LPAREN  = 7'h28;
  localparam logic [6:0] CH_RPAREN  = 7'h29;
  localparam logic [6:0] CH_PLUS    = 7'h2B;
  localparam logic [6:0] CH_COMMA   = 7'h2C;
  localparam logic [6:0] CH_MINUS   = 7'h2D;
  localparam logic [6:0] CH_DOT     = 7'h2E;
  localparam logic [6:0] CH_SLASH   = 7'h2F;
  localparam logic [6:0] CH_DIGIT_0 = 7'h30;
  localparam logic [6:0] CH_DIGIT_9 = 7'h39;
  localparam logic [6:0] CH_COLON   = 7'h3A;
  localparam logic [6:0] CH_QMARK   = 7'h3F;
  localparam logic [6:0] CH_UPPER_A = 7'h41;
  localparam logic [6:0] CH_UPPER_Z = 7'h5A;
  localparam logic [6:0] CH_LBRACK  = 7'h5B;
  localparam logic [6:0] CH_RBRACK  = 7'h5D;
  localparam logic [6:0] CH_UNDER   = 7'h5F;

  localparam logic [4:0] LETTER_ROWS [26][7] = '{
    '{5'd14, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd17, 5'd17, 5'd30},
    '{5'd14, 5'd17, 5'd16, 5'd16, 5'd16, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd30},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd31},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd16, 5'd23, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd17, 5'd17, 5'd31, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    '{5'd7,  5'd2,  5'd2,  5'd2,  5'd18, 5'd18, 5'd12},
    '{5'd17, 5'd18, 5'd20, 5'd24, 5'd20, 5'd18, 5'd17},
    '{5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd16, 5'd31},
    '{5'd17, 5'd27, 5'd21, 5'd21, 5'd17, 5'd17, 5'd17},
    '{5'd17, 5'd25, 5'd21, 5'd19, 5'd17, 5'd17, 5'd17},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd16, 5'd16, 5'd16},
    '{5'd14, 5'd17, 5'd17, 5'd17, 5'd21, 5'd18, 5'd13},
    '{5'd30, 5'd17, 5'd17, 5'd30, 5'd20, 5'd18, 5'd17},
    '{5'd15, 5'd16, 5'd16, 5'd14, 5'd1,  5'd1,  5'd30},
    '{5'd31, 5'd4,  5'd4,  5'd4,  5'd4,  5'd4,  5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd14},
    '{5'd17, 5'd17, 5'd17, 5'd17, 5'd17, 5'd10, 5'd4},
    '{5'd17, 5'd17, 5'd17, 5'd21, 5'd21, 5'd21, 5'd10},
    '{5'd17, 5'd17, 5'd10, 5'd4,  5'd10, 5'd17, 5'd17},
    '{5'd17, 5'd17, 5'd10, 5'd4,  5'd4,  5'd4,  5'd4},
    '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd16, 5'd31}
  };

  localparam logic [4:0] DIGIT_ROWS [10][7] = '{
    '{5'd14, 5'd17, 5'd19, 5'd21, 5'd25, 5'd17, 5'd14},
    '{5'd4,  5'd12, 5'd4,  5'd4,  5'd4,  5'd4,  5'd14},
    '{5'd14, 5'd17, 5'd1,  5'd2,  5'd4,  5'd8,  5'd31},
    '{5'd30, 5'd1,  5'd1,  5'd14, 5'd1,  5'd1,  5'd30},
    '{5'd2,  5'd6,  5'd10, 5'd18, 5'd31, 5'd2,  5'd2},
    '{5'd31, 5'd16, 5'd16, 5'd30, 5'd1,  5'd1,  5'd30},
    '{5'd14, 5'd16, 5'd16, 5'd30, 5'd17, 5'd17, 5'd14},
    '{5'd31, 5'd1,  5'd2,  5'd4,  5'd8,  5'd8,  5'd8},
    '{5'd14, 5'd17, 5'd17, 5'd14, 5'd17, 5'd17, 5'd14},
    '{5'd14, 5'd17, 5'd17, 5'd15, 5'd1,  5'd1,  5'd14}
  };

  // one queued character: everything the back end needs for 16 rows
  typedef struct packed {
    logic [11:0] x;
    logic [11:0] top;
    logic [6:0]  ch;
    logic [7:0]  fg;
    logic [7:0]  bg;
  } job_t;

  // ch is already folded to upper case and printable; r is 0..6
  function automatic logic [4:0] glyph_bits(input logic [6:0] ch, input logic [2:0] r);
    logic [6:0] li;
    logic [6:0] di;
    logic [4:0] b;
    li = ch - CH_UPPER_A;
    di = ch - CH_DIGIT_0;
    b = 5'd0;
    if (ch >= CH_UPPER_A && ch <= CH_UPPER_Z) begin
      b = LETTER_ROWS[li[4:0]][r];
    end else if (ch >= CH_DIGIT_0 && ch <= CH_DIGIT_9) begin
      b = DIGIT_ROWS[di[3:0]][r];
    end else begin
      case (ch)
        CH_DOT:     b = (r == 3'd6) ? 5'd4 : 5'd0;
        CH_COMMA:   b = (r == 3'd6) ? 5'd4 : ((r == 3'd5) ? 5'd8 : 5'd0);
        CH_MINUS:   b = (r == 3'd3) ? 5'd14 : 5'd0;
        CH_PLUS:    b = (r == 3'd3) ? 5'd14 :
                        ((r >= 3'd1 && r <= 3'd5) ? 5'd4 : 5'd0);
        CH_UNDER:   b = (r == 3'd6) ? 5'd31 : 5'd0;
        CH_COLON:   b = (r == 3'd2 || r == 3'd5) ? 5'd4 : 5'd0;
        CH_BANG:    b = (r == 3'd6 || r < 3'd5) ? 5'd4 : 5'd0;
        CH_QMARK: begin
          case (r)
            3'd0:    b = 5'd14;
            3'd1:    b = 5'd17;
            3'd2:    b = 5'd1;
            3'd3:    b = 5'd2;
            3'd4:    b = 5'd4;
            3'd6:    b = 5'd4;
            default: b = 5'd0;
          endcase
        end
        CH_LBRACK:  b = (r == 3'd0 || r == 3'd6) ? 5'd14 : 5'd8;
        CH_RBRACK:  b = (r == 3'd0 || r == 3'd6) ? 5'd14 : 5'd2;
        CH_LPAREN:  b = (r == 3'd0 || r == 3'd6) ? 5'd4 : 5'd8;
        CH_RPAREN:  b = (r == 3'd0 || r == 3'd6) ? 5'd4 : 5'd2;
        CH_SLASH:   b = (r < 3'd2) ? 5'd2 : ((r < 3'd5) ? 5'd4 : 5'd8);
        CH_PERCENT: b = (r == 3'd0 || r == 3'd5) ? 5'd10 : 5'd4;
        default:    b = 5'd0;
      endcase
    end
    return b;
  endfunction

endpackage
`default_nettype wire

### sv/grtr_if.sv
`default_nettype none
interface grtr_in_if;
  logic        valid;
  logic        ready;
  logic        start_of_string;
  logic [11:0] start_x;
  logic [11:0] start_y;
  logic [7:0]  char_code;
  logic [7:0]  fg;
  logic [7:0]  bg;

  modport source (output valid, start_of_string, start_x, start_y, char_code, fg, bg,
                  input ready);
  modport sink (input valid, start_of_string, start_x, start_y, char_code, fg, bg,
                output ready);
endinterface

interface grtr_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_x;
  logic [12:0] pixel_y;
  logic [7:0]  pix_0;
  logic [7:0]  pix_1;
  logic [7:0]  pix_2;
  logic [7:0]  pix_3;
  logic [7:0]  pix_4;
  logic [7:0]  pix_5;
  logic [7:0]  pix_6;
  logic [7:0]  pix_7;
  logic [7:0]  write_mask;
  logic        last_row;

  modport source (output valid, pixel_x, pixel_y, pix_0, pix_1, pix_2, pix_3, pix_4,
                  pix_5, pix_6, pix_7, write_mask, last_row,
                  input ready);
  modport sink (input valid, pixel_x, pixel_y, pix_0, pix_1, pix_2, pix_3, pix_4,
                pix_5, pix_6, pix_7, write_mask, last_row,
                output ready);
endinterface

interface grtr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [grtr_pkg::CFG_IDX_W-1:0]  index;
  logic [grtr_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/glyph_row_text_renderer.sv
// Glyph row text renderer: draws a string, one character per input transaction,
// as 8x16 cells built from a 5x7 character pattern.
// in_ch: one character per transaction with start_of_string, start_x, start_y,
//   char_code, fg and bg. start_of_string reloads the cursor and resumes a
//   string that hit the right canvas edge.
// out_ch: sixteen transactions per drawn character, one per glyph row, top
//   first; last_row marks the sixteenth. write_mask is zero on rows at or past
//   canvas_height. A character that would cross canvas_width, and the rest of
//   its string, produce no output.
// cfg_ch: register writes (index 0 canvas_width, 1 canvas_height); always ready.
//   Write only while no characters are in flight.
// Throughput: the row emitter sends one row per cycle while out_ch is ready;
//   skipped characters are accepted without entering the queue, when it has room.
// A small job queue sits between the input classifier and the row emitter, so
//   input is taken while rows of earlier characters are still going out.
// When out_ch stalls, the output register holds and the queue fills; in_ch
//   then drops ready until a queue slot frees.
// Reset (rst_n low, synchronous) clears cursor, stop flag, queue and output
//   valid, and loads canvas_width 600 and canvas_height 800.
`default_nettype none
module glyph_row_text_renderer #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  grtr_in_if.sink     in_ch,
  grtr_out_if.source  out_ch,
  grtr_cfg_if.sink    cfg_ch
);

  logic [12:0] canvas_width_r;
  logic [12:0] canvas_height_r;

  grtr_pkg::job_t push_job;
  logic           push_valid;
  logic           push_ready;
  grtr_pkg::job_t pop_job;
  logic           pop_valid;
  logic           pop_ready;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      canvas_width_r  <= grtr_pkg::CANVAS_WIDTH_RESET;
      canvas_height_r <= grtr_pkg::CANVAS_HEIGHT_RESET;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == grtr_pkg::REG_CANVAS_WIDTH) begin
        canvas_width_r <= cfg_ch.data;
      end
      if (cfg_ch.index == grtr_pkg::REG_CANVAS_HEIGHT) begin
        canvas_height_r <= cfg_ch.data;
      end
    end
  end

  grtr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_ch        (in_ch),
    .canvas_width (canvas_width_r),
    .push_job     (push_job),
    .push_valid   (push_valid),
    .push_ready   (push_ready)
  );

  grtr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_job   (push_job),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .rd_job   (pop_job),
    .rd_valid (pop_valid),
    .rd_ready (pop_ready)
  );

  grtr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .pop_job       (pop_job),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .canvas_height (canvas_height_r),
    .out_ch        (out_ch)
  );

endmodule
`default_nettype wire

### sv/grtr_front.sv
`default_nettype none
module grtr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  grtr_in_if.sink              in_ch,
  input  wire logic [12:0]     canvas_width,
  output grtr_pkg::job_t       push_job,
  output logic                 push_valid,
  input  wire logic            push_ready
);

  logic [12:0] cursor_x_r, cursor_x_nxt;
  logic [11:0] text_top_r, text_top_nxt;
  logic        stopped_r, stopped_nxt;

  logic [12:0] cur_x;
  logic [11:0] cur_top;
  logic        cur_stop;
  logic [13:0] right_edge;
  logic        fits;
  logic        draw;
  logic        accept;
  logic [7:0]  folded;
  logic [6:0]  norm_ch;

  assign in_ch.ready = push_ready;
  assign accept      = in_ch.valid & push_ready;

  always_comb begin
    cur_x    = in_ch.start_of_string ? {1'b0, in_ch.start_x} : cursor_x_r;
    cur_top  = in_ch.start_of_string ? in_ch.start_y : text_top_r;
    cur_stop = in_ch.start_of_string ? 1'b0 : stopped_r;
    right_edge = {1'b0, cur_x} + 14'(grtr_pkg::GLYPH_W);
    fits = right_edge <= {1'b0, canvas_width};
    draw = ~cur_stop & fits;
  end

  // fold lower case, map non-printable to '?'
  always_comb begin
    folded = in_ch.char_code;
    if (folded >= grtr_pkg::CH_LOWER_A && folded <= grtr_pkg::CH_LOWER_Z) begin
      folded = folded - grtr_pkg::CASE_DELTA;
    end
    if (folded < grtr_pkg::CH_SPACE || folded > grtr_pkg::CH_TILDE) begin
      norm_ch = grtr_pkg::CH_QMARK;
    end else begin
      norm_ch = folded[6:0];
    end
  end

  always_comb begin
    cursor_x_nxt = cursor_x_r;
    text_top_nxt = text_top_r;
    stopped_nxt  = stopped_r;
    if (accept) begin
      cursor_x_nxt = draw ? (cur_x + 13'(grtr_pkg::GLYPH_W)) : cur_x;
      text_top_nxt = cur_top;
      stopped_nxt  = cur_stop | ~fits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_x_r <= '0;
      text_top_r <= '0;
      stopped_r  <= 1'b0;
    end else begin
      cursor_x_r <= cursor_x_nxt;
      text_top_r <= text_top_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

  assign push_valid   = in_ch.valid & draw;
  assign push_job.x   = cur_x[11:0];
  assign push_job.top = cur_top;
  assign push_job.ch  = norm_ch;
  assign push_job.fg  = in_ch.fg;
  assign push_job.bg  = in_ch.bg;

endmodule
`default_nettype wire

### sv/grtr_queue.sv
`default_nettype none
module grtr_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  grtr_pkg::job_t      wr_job,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  output grtr_pkg::job_t      rd_job,
  output logic                rd_valid,
  input  wire logic           rd_ready
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  grtr_pkg::job_t  mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            do_wr, do_rd;

  assign wr_ready = count_r != CW'(DEPTH);
  assign rd_valid = count_r != '0;
  assign rd_job   = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid & wr_ready;
  assign do_rd    = rd_valid & rd_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_job;
    end
  end

endmodule
`default_nettype wire

### sv/grtr_back.sv
`default_nettype none
module grtr_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  grtr_pkg::job_t   pop_job,
  input  wire logic        pop_valid,
  output logic             pop_ready,
  input  wire logic [12:0] canvas_height,
  grtr_out_if.source       out_ch
);

  localparam logic [3:0] LAST_ROW_IDX = 4'(grtr_pkg::GLYPH_H - 1);

  grtr_pkg::job_t job_r;
  logic           active_r, active_nxt;
  logic [3:0]     row_r, row_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [11:0]    x_r;
  logic [12:0]    y_r;
  logic [7:0]     pix_r [8];
  logic [7:0]     mask_r;
  logic           last_r;

  logic           adv;
  logic           emit;
  logic           done_now;
  logic           take;
  logic [3:0]     row_m1;
  logic           blank_row;
  logic [4:0]     pattern;
  logic [7:0]     bits;
  logic [12:0]    y_cur;

  assign adv      = ~out_valid_r | out_ch.ready;
  assign emit     = adv & active_r;
  assign done_now = emit & (row_r == LAST_ROW_IDX);
  assign pop_ready = ~active_r | done_now;
  assign take     = pop_ready & pop_valid;

  always_comb begin
    row_m1    = row_r - 4'd1;
    blank_row = (row_r == 4'd0) || (row_r == LAST_ROW_IDX);
    pattern   = grtr_pkg::glyph_bits(job_r.ch, row_m1[3:1]);
    // pattern bit 4 lands at offset 2, bit 0 at offset 6
    bits      = blank_row ? 8'd0 : {2'b00, pattern, 1'b0};
    y_cur     = {1'b0, job_r.top} + {9'd0, row_r};
  end

  always_comb begin
    active_nxt    = active_r;
    row_nxt       = row_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      out_valid_nxt = active_r;
    end
    if (emit) begin
      row_nxt = row_r + 4'd1;
    end
    if (take) begin
      active_nxt = 1'b1;
      row_nxt    = 4'd0;
    end else if (done_now) begin
      active_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job_r <= pop_job;
    end
    if (emit) begin
      x_r    <= job_r.x;
      y_r    <= y_cur;
      mask_r <= (y_cur < canvas_height) ? 8'hFF : 8'h00;
      last_r <= row_r == LAST_ROW_IDX;
      for (int i = 0; i < 8; i++) begin
        pix_r[i] <= bits[7-i] ? job_r.fg : job_r.bg;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_x    = x_r;
  assign out_ch.pixel_y    = y_r;
  assign out_ch.pix_0      = pix_r[0];
  assign out_ch.pix_1      = pix_r[1];
  assign out_ch.pix_2      = pix_r[2];
  assign out_ch.pix_3      = pix_r[3];
  assign out_ch.pix_4      = pix_r[4];
  assign out_ch.pix_5      = pix_r[5];
  assign out_ch.pix_6      = pix_r[6];
  assign out_ch.pix_7      = pix_r[7];
  assign out_ch.write_mask = mask_r;
  assign out_ch.last_row   = last_r;

endmodule
`default_nettype wire
